FILE: rtl/core/rlpe_pkg.sv
// ----------------------------------------------------------------------------
// Run/literal packet encoder package
// Shared payload types, command format and constants of the encoder core.
// ----------------------------------------------------------------------------
package rlpe_pkg;

	localparam int BYTE_W          = 8;
	localparam int PACKET_LIMIT_DEF = 128;
	localparam int OUT_LANES_DEF   = 8;
	localparam logic [7:0] RUN_FLAG    = 8'h80;
	localparam logic [7:0] MIN_RUN_DEF = 8'd4;
	localparam int MIN_RUN_CAP     = 24;
	localparam int MAX_RESULTS     = 20;
	localparam int CMD_DEPTH       = 4;
	localparam int PTR_W           = $clog2(CMD_DEPTH);
	localparam int REP_W           = $clog2(MIN_RUN_CAP);
	localparam int RES_W           = $clog2(MAX_RESULTS + 1);

	// one stream item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_stream;
	} in_item_t;

	// one slice of an output packet
	typedef struct packed {
		logic [63:0] packet_bytes;
		logic [3:0]  byte_count;
		logic        end_of_packet;
		logic        end_of_output;
	} out_item_t;

	// what the back end must do with a closed run
	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_RUN,
		CMD_FLUSH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] run_value;
		logic [7:0] run_len;
		logic       item_last;
		logic       stream_end;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_APPEND,
		BK_LOAD,
		BK_EMIT
	} bk_state_t;

endpackage

FILE: rtl/core/run_literal_packet_encoder_core.sv
// ----------------------------------------------------------------------------
// Run/literal packet encoder core
// Byte stream in, run and literal packets out, up to OUT_LANES bytes per
// result. A run tracker accepts one byte per cycle while its 4-entry command
// queue has room and no second command waits, as after an item that both
// breaks a run and ends the stream. The packet writer takes a command only
// when idle; a byte that joins the literal store passes dispatch and a store
// write, and a literal flush reads one store row per output word. The user
// must write min_run_length only while the block is idle; the block does not
// enforce this. Values above 24 act as 24 and values below 1 act as 1.
// ----------------------------------------------------------------------------
module run_literal_packet_encoder_core #(
	parameter int PACKET_LIMIT = rlpe_pkg::PACKET_LIMIT_DEF,
	parameter int OUT_LANES    = rlpe_pkg::OUT_LANES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rlpe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rlpe_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);
	import rlpe_pkg::*;

	logic [7:0]   min_run_q;
	logic         push;
	cmd_t         push_cmd;
	logic         pop;
	cmd_t         head;
	fifo_status_t fifo_st;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q <= MIN_RUN_DEF;
		end else if (cfg_we) begin
			min_run_q <= cfg_wdata;
		end
	end

	rlpe_front #(
		.PACKET_LIMIT(PACKET_LIMIT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.min_run_length(min_run_q),
		.fifo_st       (fifo_st),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	rlpe_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.fifo_st (fifo_st)
	);

	rlpe_back #(
		.PACKET_LIMIT(PACKET_LIMIT),
		.OUT_LANES   (OUT_LANES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.fifo_st  (fifo_st),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// queue never overflows
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_st.full)
		else $error("command pushed into a full queue");

	// queue never underflows
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_st.empty)
		else $error("command popped from an empty queue");

	// every result carries between one and OUT_LANES bytes
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.byte_count != 4'd0)
			&& (out_data.byte_count <= 4'(OUT_LANES)))
		else $error("result byte count out of range");

endmodule

FILE: rtl/core/rlpe_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Tracks the current run and turns each closed run into a queued command.
// ----------------------------------------------------------------------------
module rlpe_front #(
	parameter int PACKET_LIMIT = rlpe_pkg::PACKET_LIMIT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rlpe_pkg::in_item_t    in_data,
	input  logic [7:0]            min_run_length,
	input  rlpe_pkg::fifo_status_t fifo_st,
	output logic                  push,
	output rlpe_pkg::cmd_t        push_cmd
);
	import rlpe_pkg::*;

	localparam int CNT_W = $clog2(PACKET_LIMIT + 1);

	logic             run_active_q;
	logic [7:0]       run_byte_q;
	logic [CNT_W-1:0] run_count_q;
	logic             second_valid_q;
	cmd_t             second_q;

	logic             accept;
	logic [7:0]       eff_min;
	logic             cont;
	logic             close_old;
	logic             n_active;
	logic [7:0]       n_byte;
	logic [CNT_W-1:0] n_cnt;
	cmd_t             old_cmd;
	cmd_t             new_cmd;
	logic             first_push;

	// hold off the source while the queue is full or a second command waits
	assign in_stall = fifo_st.full | second_valid_q;
	assign accept   = in_valid & ~in_stall;

	// clamp the threshold and classify runs
	always_comb begin
		eff_min = min_run_length;
		if (eff_min > 8'(MIN_RUN_CAP)) begin
			eff_min = 8'(MIN_RUN_CAP);
		end
		if (eff_min == 8'd0) begin
			eff_min = 8'd1;
		end

		cont = run_active_q && (in_data.data_byte == run_byte_q)
			&& (run_count_q < CNT_W'(PACKET_LIMIT));
		close_old = in_data.has_byte && run_active_q && !cont;

		n_active = run_active_q | in_data.has_byte;
		n_byte   = run_byte_q;
		n_cnt    = run_count_q;
		if (in_data.has_byte) begin
			if (cont) begin
				n_cnt = run_count_q + 1'b1;
			end else begin
				n_byte = in_data.data_byte;
				n_cnt  = CNT_W'(1);
			end
		end

		old_cmd.kind       = (8'(run_count_q) >= eff_min) ? CMD_RUN : CMD_LIT;
		old_cmd.run_value  = run_byte_q;
		old_cmd.run_len    = 8'(run_count_q);
		old_cmd.item_last  = !in_data.end_of_stream;
		old_cmd.stream_end = 1'b0;

		new_cmd.kind       = (8'(n_cnt) >= eff_min) ? CMD_RUN : CMD_LIT;
		if (!n_active) begin
			new_cmd.kind = CMD_FLUSH;
		end
		new_cmd.run_value  = n_byte;
		new_cmd.run_len    = 8'(n_cnt);
		new_cmd.item_last  = 1'b1;
		new_cmd.stream_end = 1'b1;

		first_push = close_old | in_data.end_of_stream;
	end

	// drive the queue: a waiting second command goes first
	always_comb begin
		if (second_valid_q) begin
			push     = !fifo_st.full;
			push_cmd = second_q;
		end else begin
			push     = accept & first_push;
			push_cmd = close_old ? old_cmd : new_cmd;
		end
	end

	// advance the run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q   <= 1'b0;
			run_byte_q     <= 8'd0;
			run_count_q    <= '0;
			second_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				run_byte_q <= n_byte;
				if (in_data.end_of_stream) begin
					run_active_q <= 1'b0;
					run_count_q  <= '0;
				end else begin
					run_active_q <= n_active;
					run_count_q  <= n_cnt;
				end
			end
			if (accept && close_old && in_data.end_of_stream) begin
				second_valid_q <= 1'b1;
			end else if (second_valid_q && !fifo_st.full) begin
				second_valid_q <= 1'b0;
			end
		end
	end

	// hold the closing command of the new run until the queue takes it
	always_ff @(posedge clk) begin
		if (accept && close_old && in_data.end_of_stream) begin
			second_q <= new_cmd;
		end
	end

endmodule

FILE: rtl/core/rlpe_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue that decouples the run tracker from the packet writer.
// ----------------------------------------------------------------------------
module rlpe_cmd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  rlpe_pkg::cmd_t         push_cmd,
	input  logic                   pop,
	output rlpe_pkg::cmd_t         head,
	output rlpe_pkg::fifo_status_t fifo_st
);
	import rlpe_pkg::*;

	cmd_t             entries_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign head          = entries_q[rd_ptr_q];
	assign fifo_st.full  = (fill_q == (PTR_W + 1)'(CMD_DEPTH));
	assign fifo_st.empty = (fill_q == '0);

	// store a request
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/rlpe_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Keeps the literal store and writes run and literal packets lane by lane.
// ----------------------------------------------------------------------------
module rlpe_back #(
	parameter int PACKET_LIMIT = rlpe_pkg::PACKET_LIMIT_DEF,
	parameter int OUT_LANES    = rlpe_pkg::OUT_LANES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rlpe_pkg::cmd_t         head,
	input  rlpe_pkg::fifo_status_t fifo_st,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output rlpe_pkg::out_item_t    out_data
);
	import rlpe_pkg::*;

	localparam int ROW_W  = OUT_LANES * BYTE_W;
	localparam int ROWS   = (PACKET_LIMIT + OUT_LANES - 1) / OUT_LANES;
	localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
	localparam int CNT_W  = $clog2(PACKET_LIMIT + 1);
	localparam int REM_W  = $clog2(PACKET_LIMIT + OUT_LANES + 2);

	// literal store, one row per output word
	logic [ROW_W-1:0]  store_q [ROWS];
	logic [ROW_W-1:0]  rd_data_q;

	bk_state_t         state_q;
	bk_state_t         state_d;
	cmd_t              cmd_q;
	cmd_t              cur;
	logic [REP_W-1:0]  reps_q;
	logic [CNT_W-1:0]  lit_cnt_q;
	logic [CNT_W-1:0]  lit_cnt_next;
	logic [ADDR_W-1:0] wr_row_q;
	logic [LANE_W-1:0] wr_lane_q;
	logic [ADDR_W-1:0] rd_row_q;
	logic [ADDR_W-1:0] rd_next;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        carry_q;
	logic [REM_W-1:0]  rem_q;
	logic              src_run_q;
	logic [RES_W-1:0]  res_cnt_q;
	logic              pend_valid_q;
	logic              pend_sealed_q;
	out_item_t         pend_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              wr_en;
	logic              rd_en;
	logic              go_load;
	logic              go_emit;
	logic              go_run;
	logic              go_append;
	logic              finish;
	logic              emit;
	logic              lit_clear;
	logic              keep;
	logic              out_free;
	logic              emit_ok;
	logic              new_word;
	logic              move;
	logic              seal_now;
	logic [7:0]        cur_len_m1;
	logic [ROW_W-1:0]  src_row;
	logic [ROW_W+7:0]  cat;
	logic [ROW_W-1:0]  word_masked;
	logic [REM_W-1:0]  rem_lanes;
	logic              word_last;
	logic [3:0]        word_cnt;
	out_item_t         new_item;

	assign cur          = (state_q == BK_IDLE) ? head : cmd_q;
	assign cur_len_m1   = cur.run_len - 8'd1;
	assign lit_cnt_next = lit_cnt_q + 1'b1;
	assign rd_next      = (rd_row_q == ADDR_W'(ROWS - 1)) ? rd_row_q : rd_row_q + 1'b1;
	assign keep         = res_cnt_q < RES_W'(MAX_RESULTS);
	assign out_free     = !out_valid_q || !out_stall;
	assign emit_ok      = !keep || !pend_valid_q || out_free;

	// assemble the current output word from the row and the carried byte
	always_comb begin
		src_row   = src_run_q ? ROW_W'(cmd_q.run_value) : rd_data_q;
		cat       = {src_row, carry_q};
		rem_lanes = REM_W'(OUT_LANES);
		word_last = rem_q <= rem_lanes;
		word_cnt  = word_last ? 4'(rem_q) : 4'(OUT_LANES);
		for (int i = 0; i < OUT_LANES; i++) begin
			word_masked[i*BYTE_W +: BYTE_W] = (4'(i) < word_cnt) ?
				cat[i*BYTE_W +: BYTE_W] : 8'd0;
		end
		new_item.packet_bytes  = 64'(word_masked);
		new_item.byte_count    = word_cnt;
		new_item.end_of_packet = word_last;
		new_item.end_of_output = finish && cur.item_last && cur.stream_end;
	end

	// sequencer actions
	always_comb begin
		pop       = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		go_load   = 1'b0;
		go_emit   = 1'b0;
		go_run    = 1'b0;
		go_append = 1'b0;
		finish    = 1'b0;
		emit      = 1'b0;
		lit_clear = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_st.empty) begin
					pop = 1'b1;
					case (head.kind)
						CMD_RUN: begin
							if (lit_cnt_q != '0) go_load = 1'b1;
							else go_run = 1'b1;
						end
						CMD_LIT: go_append = 1'b1;
						default: begin
							if (lit_cnt_q != '0) go_load = 1'b1;
							else finish = 1'b1;
						end
					endcase
				end
			end
			BK_APPEND: begin
				wr_en = 1'b1;
				if (lit_cnt_next == CNT_W'(PACKET_LIMIT)) begin
					go_load = 1'b1;
				end else if (reps_q == REP_W'(1)) begin
					if (cmd_q.stream_end) go_load = 1'b1;
					else finish = 1'b1;
				end
			end
			BK_LOAD: begin
				rd_en   = 1'b1;
				go_emit = 1'b1;
			end
			BK_EMIT: begin
				if (emit_ok) begin
					emit = 1'b1;
					if (!word_last) begin
						rd_en   = 1'b1;
						rd_addr = rd_next;
					end else begin
						lit_clear = !src_run_q;
						if (src_run_q) finish = 1'b1;
						else if (cmd_q.kind == CMD_RUN) go_run = 1'b1;
						else if (reps_q != '0) go_append = 1'b1;
						else finish = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		if (go_load) begin
			state_d = BK_LOAD;
		end else if (go_run || go_emit) begin
			state_d = BK_EMIT;
		end else if (go_append) begin
			state_d = BK_APPEND;
		end else if (finish) begin
			state_d = BK_IDLE;
		end
	end

	// hand-off between the word under assembly and the output register
	assign new_word = emit && keep;
	assign move     = out_free && pend_valid_q && (pend_sealed_q || new_word);
	assign seal_now = finish && cur.item_last && !new_word && pend_valid_q && !pend_sealed_q;

	// store write and registered row read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_row_q][{wr_lane_q, 3'b000} +: BYTE_W] <= cmd_q.run_value;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			lit_cnt_q     <= '0;
			wr_row_q      <= '0;
			wr_lane_q     <= '0;
			src_run_q     <= 1'b0;
			res_cnt_q     <= '0;
			pend_valid_q  <= 1'b0;
			pend_sealed_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// literal fill position
			if (lit_clear) begin
				lit_cnt_q <= '0;
				wr_row_q  <= '0;
				wr_lane_q <= '0;
			end else if (wr_en) begin
				lit_cnt_q <= lit_cnt_next;
				if (wr_lane_q == LANE_W'(OUT_LANES - 1)) begin
					wr_lane_q <= '0;
					if (wr_row_q != ADDR_W'(ROWS - 1)) begin
						wr_row_q <= wr_row_q + 1'b1;
					end
				end else begin
					wr_lane_q <= wr_lane_q + 1'b1;
				end
			end

			if (go_run) begin
				src_run_q <= 1'b1;
			end else if (go_emit) begin
				src_run_q <= 1'b0;
			end

			// results of the current item, drop beyond the cap
			if (finish && cur.item_last) begin
				res_cnt_q <= '0;
			end else if (new_word) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end

			if (new_word) begin
				pend_valid_q  <= 1'b1;
				pend_sealed_q <= finish && cur.item_last;
			end else if (move) begin
				pend_valid_q  <= 1'b0;
				pend_sealed_q <= 1'b0;
			end else if (seal_now) begin
				pend_sealed_q <= 1'b1;
			end

			if (move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command, packet walk and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q  <= head;
			reps_q <= (head.kind == CMD_LIT) ? REP_W'(head.run_len) : '0;
		end else if (wr_en) begin
			reps_q <= reps_q - 1'b1;
		end

		if (go_run) begin
			carry_q <= RUN_FLAG | {1'b0, cur_len_m1[6:0]};
			rem_q   <= REM_W'(2);
		end else if (go_emit) begin
			carry_q  <= 8'(lit_cnt_q - 1'b1);
			rem_q    <= REM_W'(lit_cnt_q) + 1'b1;
			rd_row_q <= '0;
		end else if (emit) begin
			carry_q <= src_row[ROW_W-1 -: BYTE_W];
			rem_q   <= rem_q - rem_lanes;
			if (rd_en) begin
				rd_row_q <= rd_next;
			end
		end

		if (new_word) begin
			pend_q <= new_item;
		end else if (seal_now) begin
			pend_q.end_of_output <= cur.stream_end;
		end

		if (move) begin
			out_q <= pend_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run/literal packet encoder testbench
// Streams bytes into the encoder core and checks every packet word it returns
// against a packet predictor kept in step with each accepted request. Directed
// streams cover run and literal packets, the threshold clamp and end markers.
// Random streams follow, then a long output hold-off that fills the core.
// ----------------------------------------------------------------------------
module tb_top;
	import rlpe_pkg::*;

	localparam int SETTLE_CYCLES   = 64;
	localparam int HOLD_OFF_CYCLES = 300;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	// idling control
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct    = 0;
	logic        hold_toggle  = 1'b0;
	logic        hold_seen    = 1'b0;
	int unsigned hold_left    = 0;

	// packet predictor state
	logic [7:0]  lit_mem [PACKET_LIMIT_DEF];
	int unsigned lit_len     = 0;
	logic        run_open    = 1'b0;
	logic [7:0]  run_val     = '0;
	int unsigned run_len     = 0;
	logic [7:0]  min_run_reg = MIN_RUN_DEF;
	logic [7:0]  pkt_buf [PACKET_LIMIT_DEF + 1];
	out_item_t   item_words[$];
	out_item_t   packet_words_due[$];
	int unsigned mismatch_count = 0;

	run_literal_packet_encoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Split one packet from pkt_buf into words of up to eight bytes
	function automatic void emit_packet(input int unsigned len);
		int unsigned pos;
		int unsigned take;
		out_item_t   word;
		pos = 0;
		while (pos < len) begin
			take = (len - pos > OUT_LANES_DEF) ? OUT_LANES_DEF : len - pos;
			word = '0;
			for (int k = 0; k < take; k++) begin
				word.packet_bytes[8*k +: 8] = pkt_buf[pos + k];
			end
			pos += take;
			word.byte_count    = 4'(take);
			word.end_of_packet = (pos >= len);
			// drop anything past the per-request cap
			if (item_words.size() < MAX_RESULTS) begin
				item_words.push_back(word);
			end
		end
	endfunction

	function automatic void flush_literals();
		if (lit_len == 0) begin
			return;
		end
		pkt_buf[0] = 8'(lit_len - 1);
		for (int k = 0; k < lit_len; k++) begin
			pkt_buf[k + 1] = lit_mem[k];
		end
		emit_packet(lit_len + 1);
		lit_len = 0;
	endfunction

	function automatic void append_literal(input logic [7:0] value);
		if (lit_len < PACKET_LIMIT_DEF) begin
			lit_mem[lit_len] = value;
			lit_len++;
		end
		// a full store goes out at once
		if (lit_len >= PACKET_LIMIT_DEF) begin
			flush_literals();
		end
	endfunction

	// Shortest run sent as a run packet, after the clamp
	function automatic int unsigned run_threshold();
		if (min_run_reg > MIN_RUN_CAP) begin
			return MIN_RUN_CAP;
		end
		if (min_run_reg < 1) begin
			return 1;
		end
		return min_run_reg;
	endfunction

	function automatic void close_run();
		if (run_len >= run_threshold()) begin
			flush_literals();
			pkt_buf[0] = RUN_FLAG | (8'(run_len - 1) & 8'h7F);
			pkt_buf[1] = run_val;
			emit_packet(2);
		end else begin
			for (int k = 0; k < run_len; k++) begin
				append_literal(run_val);
			end
		end
		run_len = 0;
	endfunction

	// Advance the encoder state by one request and queue the words it causes
	function automatic void encode_item(input in_item_t req);
		item_words.delete();
		if (req.has_byte) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_val  = req.data_byte;
				run_len  = 1;
			end else if (req.data_byte == run_val && run_len < PACKET_LIMIT_DEF) begin
				run_len++;
			end else begin
				close_run();
				run_val = req.data_byte;
				run_len = 1;
			end
		end
		if (req.end_of_stream) begin
			if (run_open) begin
				close_run();
			end
			run_open = 1'b0;
			run_len  = 0;
			flush_literals();
			if (item_words.size() > 0) begin
				item_words[item_words.size() - 1].end_of_output = 1'b1;
			end
		end
		foreach (item_words[i]) begin
			packet_words_due.push_back(item_words[i]);
		end
	endfunction

	// Offer one request after a random gap and hold it until taken
	task automatic send_item(input logic [7:0] value, input logic has, input logic eos);
		in_item_t req;
		req.data_byte     = value;
		req.has_byte      = has;
		req.end_of_stream = eos;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (in_stall);
		encode_item(req);
	endtask

	task automatic send_run(input logic [7:0] value, input int unsigned len);
		for (int k = 0; k < len; k++) begin
			send_item(value, 1'b1, 1'b0);
		end
	endtask

	// Drop valid, wait for every expected word, then let the core settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (packet_words_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_run(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		min_run_reg = value;
	endtask

	// Random stream of runs with stray idle requests, closed by an end marker
	task automatic send_random_stream(input int unsigned budget, inout int unsigned sent);
		int unsigned taken;
		int unsigned seg_len;
		int unsigned roll;
		logic [7:0]  seg_val;
		taken = 0;
		while (taken < budget) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				seg_len = $urandom_range(1, 3);
			end else if (roll < 85) begin
				seg_len = $urandom_range(4, 10);
			end else if (roll < 98) begin
				seg_len = $urandom_range(11, 30);
			end else begin
				seg_len = $urandom_range(120, 135);
			end
			seg_val = 8'($urandom_range(255));
			for (int k = 0; k < seg_len; k++) begin
				if ($urandom_range(99) < 5) begin
					send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				end
				send_item(seg_val, 1'b1, 1'b0);
			end
			taken += seg_len;
		end
		if ($urandom_range(1) != 0) begin
			send_item(8'($urandom_range(255)), 1'b1, 1'b1);
		end else begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		end
		// a second marker on an empty encoder
		if ($urandom_range(99) < 10) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		end
		sent += taken + 1;
	endtask

	task automatic test_directed();
		logic [7:0] mixed [8] = '{8'h01, 8'h80, 8'h7F, 8'h55, 8'hC3, 8'h3C, 8'h10, 8'hE7};
		send_gap_pct = 6;
		stall_pct    = 62;
		// end marker and idle request on an empty encoder
		send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		send_item(8'($urandom_range(255)), 1'b0, 1'b0);
		// run at the default threshold broken by a short run ending the stream
		send_run(8'h00, 4);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// short literal closed by an empty end marker
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'h34, 1'b1, 1'b0);
		send_item(8'h56, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// nine-byte literal packet flushed ahead of a run that ends the stream
		foreach (mixed[i]) begin
			send_item(mixed[i], 1'b1, 1'b0);
		end
		send_run(8'hAA, 3);
		send_item(8'hAA, 1'b1, 1'b1);
	endtask

	task automatic test_run_thresholds();
		logic [7:0]  limits [5] = '{8'd2, 8'd3, 8'd24, 8'd25, 8'd128};
		logic [7:0]  first_val;
		int unsigned thr;
		send_gap_pct = 20;
		stall_pct    = 20;
		foreach (limits[i]) begin
			wait_drained();
			write_min_run(limits[i]);
			thr       = run_threshold();
			first_val = 8'($urandom_range(255));
			// one short of the threshold stays literal, the threshold makes a run
			send_run(first_val, thr - 1);
			send_run(first_val ^ 8'h5A, thr);
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		end
		wait_drained();
		write_min_run(MIN_RUN_DEF);
	endtask

	task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned hold_pct,
			input int unsigned budget);
		int unsigned sent;
		send_gap_pct = gap_pct;
		stall_pct    = hold_pct;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(99) < 30) begin
				wait_drained();
				case ($urandom_range(5))
					0: write_min_run(8'd2);
					1: write_min_run(8'd24);
					2: write_min_run(8'd25);
					3: write_min_run(8'd128);
					4: write_min_run(8'($urandom_range(2, 8)));
					default: write_min_run(8'($urandom_range(2, 128)));
				endcase
			end
			send_random_stream($urandom_range(1, 40), sent);
		end
	endtask

	// Hold the output off while the input keeps pushing long packets
	task automatic test_output_hold_off();
		logic [7:0] lit_val;
		send_gap_pct = 0;
		stall_pct    = 0;
		hold_toggle <= ~hold_toggle;
		lit_val = 8'($urandom_range(255));
		// literal stretch past the store limit
		repeat (130) begin
			send_item(lit_val, 1'b1, 1'b0);
			lit_val ^= 8'($urandom_range(1, 255));
		end
		// run past the packet limit
		send_run(lit_val, 130);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	// Output side: long hold-off on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_OFF_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each accepted word with the oldest expected one
	always @(posedge clk) begin : check_words
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (packet_words_due.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("%0t: unexpected word bytes=%h count=%0d eop=%b eoo=%b", $time,
						out_data.packet_bytes, out_data.byte_count,
						out_data.end_of_packet, out_data.end_of_output);
				end
				mismatch_count++;
			end else begin
				want = packet_words_due.pop_front();
				if (out_data.packet_bytes !== want.packet_bytes
						|| out_data.byte_count !== want.byte_count
						|| out_data.end_of_packet !== want.end_of_packet
						|| out_data.end_of_output !== want.end_of_output) begin
					if (mismatch_count < 10) begin
						$display("%0t: word mismatch", $time);
						$display("  expected bytes=%h count=%0d eop=%b eoo=%b",
							want.packet_bytes, want.byte_count,
							want.end_of_packet, want.end_of_output);
						$display("  actual   bytes=%h count=%0d eop=%b eoo=%b",
							out_data.packet_bytes, out_data.byte_count,
							out_data.end_of_packet, out_data.end_of_output);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_run_thresholds();
		test_random_traffic(6, 62, 45);
		test_random_traffic(62, 6, 45);
		test_random_traffic(0, 0, 45);
		test_output_hold_off();
		wait_drained();
		if (mismatch_count == 0 && packet_words_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/rlpe_pkg.sv
rtl/core/rlpe_front.sv
rtl/core/rlpe_cmd_fifo.sv
rtl/core/rlpe_back.sv
rtl/core/run_literal_packet_encoder_core.sv
verif/tb_top.sv
